@@ rtl/core/rotated_rectangle_pixel_scan_core_defines.svh @@
// Assertion macros shared by the pixel scan checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ROTATED_RECTANGLE_PIXEL_SCAN_CORE_DEFINES_SVH
`define ROTATED_RECTANGLE_PIXEL_SCAN_CORE_DEFINES_SVH

// Checked only outside reset.
`define RRPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RRPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rrps_pkg.sv @@
// Package for the rotated rectangle pixel scan core.
// Holds fixed widths, controller states and controller/datapath command types.
`timescale 1ns / 1ps
package rrps_pkg;

  localparam int OUT_W    = 16;
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = 14;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OFF,
    S_CORN,
    S_INIT,
    S_ROW,
    S_CHECK,
    S_COL,
    S_ELOAD,
    S_EMUL,
    S_DSTART,
    S_EDIV,
    S_EFIN,
    S_NEWROW,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       latch_in;
    logic       mul_off;
    logic [1:0] off_idx;
    logic       build_corners;
    logic       init_scan;
    logic       step_row;
    logic       set_fin;
    logic       inc_col;
    logic       edge_load;
    logic       edge_upper;
    logic       edge_mul;
    logic       edge_vert;
    logic       div_start;
    logic       edge_store;
    logic       new_row;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic loop_go;
    logic col_past;
    logic vertical;
    logic div_done;
    logic finished;
  } dp_sts_t;

endpackage

@@ rtl/core/rrps_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by rrps_datapath for the edge interpolation.
`timescale 1ns / 1ps
module rrps_div #(
  parameter int NW = 50,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      trial;

  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign trial  = rem_sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NW);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        quo_nxt = {quo_r[NW-2:0], ~trial[DW]};
        rem_nxt = trial[DW] ? rem_sh[DW-1:0] : trial[DW-1:0];
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = busy_r && (cnt_r == '0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/rrps_datapath.sv @@
// Datapath of the pixel scan core: corners, scan position, edge limits, output register.
// Depends on rrps_pkg and rrps_div; driven by rrps_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
module rrps_datapath #(
  parameter int COORD_INT_BITS  = 16,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  rrps_pkg::dp_cmd_t                             cmd,
  output rrps_pkg::dp_sts_t                             sts,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_seg_end_y,
  input  logic signed [rrps_pkg::DIR_W-1:0]             in_dir_cos,
  input  logic signed [rrps_pkg::DIR_W-1:0]             in_dir_sin,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_near_offset,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_far_offset,
  output logic signed [rrps_pkg::OUT_W-1:0]             out_pixel_x,
  output logic signed [rrps_pkg::OUT_W-1:0]             out_pixel_y,
  output logic                                          out_done_res
);

  import rrps_pkg::*;

  localparam int FRAC   = COORD_FRAC_BITS;
  localparam int CW     = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int SPAN_W = CW + 2;
  localparam int ROW_W  = COORD_INT_BITS + 1;
  localparam int XW     = ROW_W + FRAC;
  localparam int DXW    = CW + 2;
  localparam int DYW    = CW + 1;
  localparam int PW     = DXW + DYW;
  localparam int NW     = PW - 1;
  localparam int DW     = CW + 1;
  localparam int SW     = NW + 3;
  localparam int OFF_PW = DIR_W + CW;
  localparam int OFF_W  = OFF_PW - DIR_FRAC;
  localparam int CLW    = SPAN_W + 1 - FRAC;
  localparam int EXT_W  = (ROW_W > OUT_W) ? ROW_W : OUT_W;

  localparam logic signed [CW+2:0] CW_MAX = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] CW_MIN = {4'b1111, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] SP_MAX = {{(SW-SPAN_W+1){1'b0}}, {(SPAN_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SP_MIN = {{(SW-SPAN_W+1){1'b1}}, {(SPAN_W-1){1'b0}}};
  localparam logic signed [CLW-1:0] RW_MAX = {{(CLW-ROW_W+1){1'b0}}, {(ROW_W-1){1'b1}}};
  localparam logic signed [CLW-1:0] RW_MIN = {{(CLW-ROW_W+1){1'b1}}, {(ROW_W-1){1'b0}}};
  localparam logic signed [SPAN_W-1:0] SPAN_NEG = {1'b1, {(SPAN_W-1){1'b0}}};
  localparam logic signed [OFF_PW-1:0] OFF_RND = OFF_PW'(1) <<< (DIR_FRAC - 1);

  // latched load item
  logic signed [CW-1:0]    x1_r, y1_r, x2_r, y2_r, wmin_r, wmax_r;
  logic signed [DIR_W-1:0] dx_r, dy_r;
  logic signed [OFF_W-1:0] off_r [4];

  logic signed [CW-1:0]     cx_r [4];
  logic signed [CW-1:0]     cy_r [4];
  logic signed [ROW_W-1:0]  col_r, row_r;
  logic signed [SPAN_W-1:0] lo_r, hi_r;
  logic                     finished_r;

  logic signed [CW-1:0] ex1_r, ey1_r, ex2_r, ey2_r;
  logic signed [XW-1:0] xv_r;
  logic signed [PW-1:0] prod_r;
  logic signed [DW-1:0] den_r;
  logic                 neg_r;

  logic signed [OUT_W-1:0] pix_x_r, pix_y_r;
  logic                    done_r;

  // offset multiplier
  logic signed [DIR_W-1:0]  mul_a;
  logic signed [CW-1:0]     mul_b;
  logic signed [OFF_PW-1:0] offp, offr;

  always_comb begin
    case (cmd.off_idx)
      2'd0:    begin mul_a = dy_r; mul_b = wmax_r; end
      2'd1:    begin mul_a = dx_r; mul_b = wmax_r; end
      2'd2:    begin mul_a = dy_r; mul_b = wmin_r; end
      default: begin mul_a = dx_r; mul_b = wmin_r; end
    endcase
  end

  assign offp = OFF_PW'(mul_a) * OFF_PW'(mul_b);
  assign offr = offp + OFF_RND;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [CW+2:0] v);
    logic signed [CW-1:0] r;
    if (v > CW_MAX)      r = CW_MAX[CW-1:0];
    else if (v < CW_MIN) r = CW_MIN[CW-1:0];
    else                 r = v[CW-1:0];
    return r;
  endfunction

  // corners before rotation; off_r: 0 dy*far, 1 dx*far, 2 dy*near, 3 dx*near
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  logic [1:0]           rot;

  always_comb begin
    px[0] = sat_cw((CW+3)'(x1_r) - (CW+3)'(off_r[0]));
    py[0] = sat_cw((CW+3)'(y1_r) + (CW+3)'(off_r[1]));
    px[1] = sat_cw((CW+3)'(x2_r) - (CW+3)'(off_r[0]));
    py[1] = sat_cw((CW+3)'(y2_r) + (CW+3)'(off_r[1]));
    px[2] = sat_cw((CW+3)'(x2_r) - (CW+3)'(off_r[2]));
    py[2] = sat_cw((CW+3)'(y2_r) + (CW+3)'(off_r[3]));
    px[3] = sat_cw((CW+3)'(x1_r) - (CW+3)'(off_r[2]));
    py[3] = sat_cw((CW+3)'(y1_r) + (CW+3)'(off_r[3]));
    if (x1_r < x2_r && y1_r <= y2_r)       rot = 2'd0;
    else if (x1_r >= x2_r && y1_r < y2_r)  rot = 2'd1;
    else if (x1_r > x2_r && y1_r >= y2_r)  rot = 2'd2;
    else                                   rot = 2'd3;
  end

  // ceil(v / 2^FRAC) on the leftmost corner
  logic signed [CW:0]      cx0_adj, cy0_adj;
  logic signed [ROW_W-1:0] col_init, row_init;

  assign cx0_adj  = (CW+1)'(cx_r[0]) + (CW+1)'({FRAC{1'b1}});
  assign cy0_adj  = (CW+1)'(cy_r[0]) + (CW+1)'({FRAC{1'b1}});
  assign col_init = ROW_W'(cx0_adj >>> FRAC) - ROW_W'(1);
  assign row_init = ROW_W'(cy0_adj >>> FRAC);

  // scan position in Q format
  logic signed [XW-1:0] col_x, row_x;
  logic                 col_past;

  assign col_x    = {col_r, {FRAC{1'b0}}};
  assign row_x    = {row_r, {FRAC{1'b0}}};
  assign col_past = col_x > XW'(cx_r[2]);

  // edge choice for the column just entered
  always_ff @(posedge clk) begin
    if (cmd.edge_load) begin
      xv_r <= col_x;
      if (cmd.edge_upper) begin
        if (col_x < XW'(cx_r[1])) begin
          ex1_r <= cx_r[0]; ey1_r <= cy_r[0]; ex2_r <= cx_r[1]; ey2_r <= cy_r[1];
        end else begin
          ex1_r <= cx_r[1]; ey1_r <= cy_r[1]; ex2_r <= cx_r[2]; ey2_r <= cy_r[2];
        end
      end else begin
        if (col_x < XW'(cx_r[3])) begin
          ex1_r <= cx_r[0]; ey1_r <= cy_r[0]; ex2_r <= cx_r[3]; ey2_r <= cy_r[3];
        end else begin
          ex1_r <= cx_r[3]; ey1_r <= cy_r[3]; ex2_r <= cx_r[2]; ey2_r <= cy_r[2];
        end
      end
    end
  end

  logic signed [DXW-1:0] dxv;
  logic signed [DYW-1:0] dyv;
  logic signed [PW-1:0]  prod_abs;
  logic signed [DW-1:0]  den_abs;

  assign dxv      = DXW'(xv_r) - DXW'(ex1_r);
  assign dyv      = DYW'(ey2_r) - DYW'(ey1_r);
  assign prod_abs = prod_r[PW-1] ? -prod_r : prod_r;
  assign den_abs  = den_r[DW-1] ? -den_r : den_r;

  logic          div_done;
  logic [NW-1:0] div_q;
  logic [DW-1:0] div_r;

  rrps_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_abs[NW-1:0]),
    .den   (den_abs),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  // lower limit rounds up, upper limit rounds down
  logic                 q_rnd;
  logic [NW:0]          q_mag;
  logic signed [NW+1:0] q_s;
  logic signed [SW-1:0] sum;
  logic signed [SPAN_W-1:0] edge_val, vert_val;

  always_comb begin
    q_rnd = (div_r != '0) && (cmd.edge_upper == neg_r);
    q_mag = {1'b0, div_q} + (NW+1)'(q_rnd);
    q_s   = neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    sum   = SW'(ey1_r) + SW'(q_s);
    if (sum > SP_MAX)      edge_val = SP_MAX[SPAN_W-1:0];
    else if (sum < SP_MIN) edge_val = SP_MIN[SPAN_W-1:0];
    else                   edge_val = sum[SPAN_W-1:0];
    if (cmd.edge_upper) vert_val = (ey1_r > ey2_r) ? SPAN_W'(ey1_r) : SPAN_W'(ey2_r);
    else                vert_val = (ey1_r < ey2_r) ? SPAN_W'(ey1_r) : SPAN_W'(ey2_r);
  end

  // first row of a new column
  logic signed [SPAN_W:0]  lo_adj;
  logic signed [CLW-1:0]   lo_ceil;
  logic signed [ROW_W-1:0] row_new;

  always_comb begin
    lo_adj  = (SPAN_W+1)'(lo_r) + (SPAN_W+1)'({FRAC{1'b1}});
    lo_ceil = CLW'(lo_adj >>> FRAC);
    if (lo_ceil > RW_MAX)      row_new = RW_MAX[ROW_W-1:0];
    else if (lo_ceil < RW_MIN) row_new = RW_MIN[ROW_W-1:0];
    else                       row_new = lo_ceil[ROW_W-1:0];
  end

  logic signed [EXT_W-1:0] col_ext, row_ext;
  assign col_ext = EXT_W'(col_r);
  assign row_ext = EXT_W'(row_r);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      x1_r   <= in_seg_start_x;
      y1_r   <= in_seg_start_y;
      x2_r   <= in_seg_end_x;
      y2_r   <= in_seg_end_y;
      dx_r   <= in_dir_cos;
      dy_r   <= in_dir_sin;
      wmin_r <= in_near_offset;
      wmax_r <= in_far_offset;
    end
    if (cmd.mul_off) off_r[cmd.off_idx] <= offr[OFF_PW-1:DIR_FRAC];
    if (cmd.build_corners) begin
      for (int n = 0; n < 4; n++) begin
        cx_r[n] <= px[2'(rot + 2'(n))];
        cy_r[n] <= py[2'(rot + 2'(n))];
      end
    end
    if (cmd.init_scan) begin
      col_r <= col_init;
      row_r <= row_init;
      lo_r  <= SPAN_NEG;
      hi_r  <= SPAN_NEG;
    end
    if (cmd.step_row && !col_past) row_r <= row_r + 1'b1;
    if (cmd.inc_col) col_r <= col_r + 1'b1;
    if (cmd.edge_mul) begin
      prod_r <= PW'(dxv) * PW'(dyv);
      den_r  <= DW'(ex2_r) - DW'(ex1_r);
    end
    if (cmd.div_start) neg_r <= prod_r[PW-1] ^ den_r[DW-1];
    if (cmd.edge_vert || cmd.edge_store) begin
      if (cmd.edge_upper) hi_r <= cmd.edge_vert ? vert_val : edge_val;
      else                lo_r <= cmd.edge_vert ? vert_val : edge_val;
    end
    if (cmd.new_row) row_r <= row_new;
    if (cmd.out_load) begin
      pix_x_r <= finished_r ? '0 : col_ext[OUT_W-1:0];
      pix_y_r <= finished_r ? '0 : row_ext[OUT_W-1:0];
      done_r  <= finished_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r <= 1'b1;
    end else if (cmd.set_fin) begin
      finished_r <= col_past;
    end
  end

  assign sts.loop_go  = (SPAN_W'(row_x) > hi_r) && !col_past;
  assign sts.col_past = col_past;
  assign sts.vertical = (ex1_r == ex2_r);
  assign sts.div_done = div_done;
  assign sts.finished = finished_r;

  assign out_pixel_x  = pix_x_r;
  assign out_pixel_y  = pix_y_r;
  assign out_done_res = done_r;

endmodule

@@ rtl/core/rrps_ctrl.sv @@
// Controller of the pixel scan core: sequences load, row step, column interpolation.
// Depends on rrps_pkg; drives rrps_datapath through dp_cmd_t.
`timescale 1ns / 1ps
module rrps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rrps_pkg::dp_sts_t sts,
  output rrps_pkg::dp_cmd_t cmd
);

  import rrps_pkg::*;

  localparam logic ACT_LOAD = 1'b0;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       upper_r, upper_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    upper_nxt = upper_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt = 2'd0;
          if (in_action == ACT_LOAD) state_nxt = S_OFF;
          else if (sts.finished)     state_nxt = S_OUT;
          else                       state_nxt = S_ROW;
        end
      end
      S_OFF: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd3) state_nxt = S_CORN;
      end
      S_CORN:  state_nxt = S_INIT;
      S_INIT:  state_nxt = S_ROW;
      S_ROW:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = sts.loop_go ? S_COL : S_OUT;
      S_COL: begin
        upper_nxt = 1'b0;
        state_nxt = sts.col_past ? S_OUT : S_ELOAD;
      end
      S_ELOAD: state_nxt = S_EMUL;
      S_EMUL: begin
        if (!sts.vertical) begin
          state_nxt = S_DSTART;
        end else if (upper_r) begin
          state_nxt = S_NEWROW;
        end else begin
          upper_nxt = 1'b1;
          state_nxt = S_ELOAD;
        end
      end
      S_DSTART: state_nxt = S_EDIV;
      S_EDIV:   if (sts.div_done) state_nxt = S_EFIN;
      S_EFIN: begin
        if (upper_r) begin
          state_nxt = S_NEWROW;
        end else begin
          upper_nxt = 1'b1;
          state_nxt = S_ELOAD;
        end
      end
      S_NEWROW: state_nxt = S_CHECK;
      S_OUT:    if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.off_idx    = cnt_r;
    cmd.edge_upper = upper_r;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_OFF:    cmd.mul_off       = 1'b1;
      S_CORN:   cmd.build_corners = 1'b1;
      S_INIT:   cmd.init_scan     = 1'b1;
      S_ROW:    cmd.step_row      = 1'b1;
      S_CHECK: begin
        cmd.inc_col = sts.loop_go;
        cmd.set_fin = !sts.loop_go;
      end
      S_COL:    cmd.set_fin   = sts.col_past;
      S_ELOAD:  cmd.edge_load = 1'b1;
      S_EMUL: begin
        cmd.edge_vert = sts.vertical;
        cmd.edge_mul  = !sts.vertical;
      end
      S_DSTART: cmd.div_start  = 1'b1;
      S_EDIV:   cmd.div_start  = 1'b0;
      S_EFIN:   cmd.edge_store = 1'b1;
      S_NEWROW: cmd.new_row    = 1'b1;
      S_OUT:    cmd.out_load   = slot_free;
      default:  cmd            = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      upper_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      upper_r     <= upper_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/rotated_rectangle_pixel_scan_core.sv @@
// Rotated rectangle pixel scan core: walks integer pixels inside a rotated rectangle.
// Instantiates rrps_ctrl and rrps_datapath; types from rrps_pkg.
//
// Input channel (in_valid/in_ready): one transaction per request. in_action low
// loads a new rectangle (centre segment, unit direction, near/far offsets) and
// returns its first pixel; in_action high returns the next pixel.
// Output channel (out_valid/out_ready): exactly one transaction per request,
// pixel_x/pixel_y of the point, or done_res high with zero coordinates once
// the scan has passed the rightmost corner.
// One request is in flight at a time. A next-point request steps the row and
// returns it when it lies in the same column, and returns done without scanning
// when the scan is already done; each new column adds an edge interpolation for
// each of the lower and upper limits on the shared restoring divider (one
// quotient bit per cycle; a vertical edge needs no division) plus column
// stepping; a load adds the corner offsets and ordering. in_ready returns in the
// cycle after the result is loaded.
// A finished result sits in the output register while the next request is
// taken; a stalled receiver holds that register and parks the next result
// until it is taken. Synchronous reset empties the output and leaves the
// core with no rectangle: next-point requests return done.
`timescale 1ns / 1ps
module rotated_rectangle_pixel_scan_core #(
  parameter int COORD_INT_BITS  = 16,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic                                          in_action,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_seg_end_y,
  input  logic signed [rrps_pkg::DIR_W-1:0]             in_dir_cos,
  input  logic signed [rrps_pkg::DIR_W-1:0]             in_dir_sin,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_near_offset,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_far_offset,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic signed [rrps_pkg::OUT_W-1:0]             out_pixel_x,
  output logic signed [rrps_pkg::OUT_W-1:0]             out_pixel_y,
  output logic                                          out_done_res
);

  import rrps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rrps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrps_datapath #(
    .COORD_INT_BITS  (COORD_INT_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_seg_start_x (in_seg_start_x),
    .in_seg_start_y (in_seg_start_y),
    .in_seg_end_x   (in_seg_end_x),
    .in_seg_end_y   (in_seg_end_y),
    .in_dir_cos     (in_dir_cos),
    .in_dir_sin     (in_dir_sin),
    .in_near_offset (in_near_offset),
    .in_far_offset  (in_far_offset),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_done_res   (out_done_res)
  );

endmodule

@@ rtl/core/rrps_checker.sv @@
// Port-level checker for the pixel scan core, bound to the top level.
// Depends on rrps_pkg and rotated_rectangle_pixel_scan_core_defines.svh.
`timescale 1ns / 1ps
`include "rotated_rectangle_pixel_scan_core_defines.svh"
module rrps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rrps_pkg::OUT_W-1:0]      out_pixel_x,
  input logic [rrps_pkg::OUT_W-1:0]      out_pixel_y,
  input logic                            out_done_res
);

  `RRPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_done_res), "output changed while stalled")
  `RRPS_ASSERT(a_done_zero, out_valid && out_done_res |-> out_pixel_x == '0 && out_pixel_y == '0, "done result with nonzero pixel")
  `RRPS_ASSERT(a_one_inflight, in_valid && in_ready |=> !in_ready, "second request taken while busy")
  `RRPS_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind rotated_rectangle_pixel_scan_core rrps_checker u_rrps_checker (.*);
